// ===== rtl/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants for the binary semaphore table.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int NUM_SEMAPHORES_DEF = 32;
    localparam int WAIT_SLOTS_DEF     = 16;
    localparam int ID_W               = 16;
    localparam int PROC_W             = 8;
    localparam int ACT_W              = 2;
    localparam int STS_W              = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE    = 2'd0,
        ACT_TERMINATE = 2'd1,
        ACT_DOWN      = 2'd2,
        ACT_UP        = 2'd3
    } action_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_WAIT_FULL = 3'd4,
        ST_NOT_HELD  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SLT_INIT,
        SLT_IDLE,
        SLT_SCAN
    } slt_state_t;

    typedef enum logic [1:0] {
        WL_INIT,
        WL_IDLE,
        WL_WALK,
        WL_CLEAR
    } wl_state_t;

    typedef enum logic {
        WL_OP_INSERT,
        WL_OP_RELEASE
    } wl_op_t;

    typedef enum logic [1:0] {
        TOP_INIT,
        TOP_IDLE,
        TOP_SCAN,
        TOP_LIST
    } top_state_t;

    typedef struct packed {
        logic scan;
        logic write;
        logic clear;
        logic flag;
    } slot_cmd_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic found;
        logic hit_flag;
        logic free_found;
    } slot_sts_t;

    typedef struct packed {
        logic   walk;
        logic   clear;
        wl_op_t op;
    } wl_cmd_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic hit;
        logic wake_valid;
    } wl_sts_t;

endpackage

// ===== rtl/bst_slot_table.sv =====
// ----------------------------------------------------------------------------
// bst_slot_table
// Identifier and available-flag memory with a sequential id/free-slot scan.
// ----------------------------------------------------------------------------
module bst_slot_table #(
    parameter int NUM_SEMAPHORES = bst_pkg::NUM_SEMAPHORES_DEF,
    localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bst_pkg::slot_cmd_t        cmd,
    input  logic [bst_pkg::ID_W-1:0]  key,
    input  logic [SW-1:0]             wr_slot,
    output bst_pkg::slot_sts_t        sts,
    output logic [SW-1:0]             match_slot,
    output logic [SW-1:0]             free_slot
);
    import bst_pkg::*;

    localparam int            DW    = ID_W + 1;
    localparam logic [SW-1:0] LAST  = SW'(NUM_SEMAPHORES - 1);
    localparam logic [SW:0]   COUNT = (SW + 1)'(NUM_SEMAPHORES);

    // bit ID_W: available flag, low bits: identifier
    logic [DW-1:0] mem [NUM_SEMAPHORES];

    slt_state_t    state_reg, state_next;
    logic [SW:0]   idx_reg, idx_next;
    logic [SW-1:0] cmp_idx_reg;
    logic          cmp_vld_reg;
    logic [DW-1:0] rd_data_reg;
    logic          found_reg, free_found_reg, done_reg;
    logic          hit_flag_reg;
    logic [SW-1:0] match_slot_reg, free_slot_reg;
    logic          last_cmp;
    logic          rd_en, wr_en;
    logic [SW-1:0] rd_addr, wr_addr;
    logic [DW-1:0] wr_data;

    assign last_cmp = cmp_vld_reg && (cmp_idx_reg == LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SLT_INIT:
            begin
                if (idx_reg[SW-1:0] == LAST)
                    state_next = SLT_IDLE;
            end
            SLT_IDLE:
            begin
                if (cmd.scan)
                    state_next = SLT_SCAN;
            end
            SLT_SCAN:
            begin
                if (last_cmp)
                    state_next = SLT_IDLE;
            end
            default:
                state_next = SLT_INIT;
        endcase
    end

    always_comb
    begin
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        rd_addr  = idx_reg[SW-1:0];
        wr_addr  = wr_slot;
        wr_data  = {1'b0, key};
        idx_next = idx_reg;
        unique case (state_reg)
            SLT_INIT:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[SW-1:0];
                wr_data  = '0;
                idx_next = idx_reg + (SW + 1)'(1);
            end
            SLT_IDLE:
            begin
                idx_next = '0;
                if (cmd.write)
                begin
                    wr_en   = 1'b1;
                    wr_data = cmd.clear ? '0 : {cmd.flag, key};
                end
            end
            SLT_SCAN:
            begin
                if (idx_reg < COUNT)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + (SW + 1)'(1);
                end
            end
            default:
                idx_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SLT_INIT;
            idx_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= rd_en;
            done_reg    <= (state_reg == SLT_SCAN) && last_cmp;
            if ((state_reg == SLT_IDLE) && cmd.scan)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmp_vld_reg)
            begin
                if (!found_reg && (rd_data_reg[ID_W-1:0] == key))
                    found_reg <= 1'b1;
                if (!free_found_reg && (rd_data_reg[ID_W-1:0] == '0))
                    free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_addr;
        if (cmp_vld_reg && !found_reg && (rd_data_reg[ID_W-1:0] == key))
        begin
            match_slot_reg <= cmp_idx_reg;
            hit_flag_reg   <= rd_data_reg[ID_W];
        end
        if (cmp_vld_reg && !free_found_reg && (rd_data_reg[ID_W-1:0] == '0))
            free_slot_reg <= cmp_idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign sts.ready      = (state_reg == SLT_IDLE);
    assign sts.done       = done_reg;
    assign sts.found      = found_reg;
    assign sts.hit_flag   = hit_flag_reg;
    assign sts.free_found = free_found_reg;
    assign match_slot     = match_slot_reg;
    assign free_slot      = free_slot_reg;

endmodule

// ===== rtl/bst_wait_list.sv =====
// ----------------------------------------------------------------------------
// bst_wait_list
// Wait-list memory: insert walk, release walk with wake search, row clear.
// ----------------------------------------------------------------------------
module bst_wait_list #(
    parameter int NUM_SEMAPHORES = bst_pkg::NUM_SEMAPHORES_DEF,
    parameter int WAIT_SLOTS     = bst_pkg::WAIT_SLOTS_DEF,
    localparam int SW    = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1,
    localparam int WW    = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1,
    localparam int DEPTH = NUM_SEMAPHORES * WAIT_SLOTS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bst_pkg::wl_cmd_t           cmd,
    input  logic [SW-1:0]              slot,
    input  logic [bst_pkg::PROC_W-1:0] proc,
    output bst_pkg::wl_sts_t           sts,
    output logic [bst_pkg::PROC_W-1:0] wake_proc
);
    import bst_pkg::*;

    localparam logic [WW-1:0] LAST_IDX  = WW'(WAIT_SLOTS - 1);
    localparam logic [WW:0]   COUNT     = (WW + 1)'(WAIT_SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [PROC_W-1:0] mem [DEPTH];

    wl_state_t         state_reg, state_next;
    wl_op_t            op_reg;
    logic [AW-1:0]     base_reg;
    logic [PROC_W-1:0] proc_reg;
    logic [WW:0]       idx_reg, idx_next;
    logic [AW-1:0]     init_reg;
    logic              cmp_vld_reg;
    logic [WW-1:0]     cmp_idx_reg;
    logic [PROC_W-1:0] rd_data_reg;
    logic              hit_reg, wake_vld_reg, done_reg;
    logic [PROC_W-1:0] wake_reg;
    logic              last_cmp, take;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [PROC_W-1:0] wr_data;

    assign last_cmp = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            WL_INIT:
            begin
                if (init_reg == LAST_ADDR)
                    state_next = WL_IDLE;
            end
            WL_IDLE:
            begin
                if (cmd.clear)
                    state_next = WL_CLEAR;
                else if (cmd.walk)
                    state_next = WL_WALK;
            end
            WL_WALK:
            begin
                if (last_cmp)
                    state_next = WL_IDLE;
            end
            WL_CLEAR:
            begin
                if (idx_reg[WW-1:0] == LAST_IDX)
                    state_next = WL_IDLE;
            end
            default:
                state_next = WL_INIT;
        endcase
    end

    always_comb
    begin
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        take     = 1'b0;
        rd_addr  = base_reg + AW'(idx_reg[WW-1:0]);
        wr_addr  = base_reg + AW'(cmp_idx_reg);
        wr_data  = '0;
        idx_next = idx_reg;
        unique case (state_reg)
            WL_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = init_reg;
            end
            WL_IDLE:
                idx_next = '0;
            WL_WALK:
            begin
                if (idx_reg < COUNT)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + (WW + 1)'(1);
                end
                if (cmp_vld_reg && !hit_reg)
                begin
                    unique case (op_reg)
                        WL_OP_INSERT:
                        begin
                            if (rd_data_reg == '0)
                            begin
                                take    = 1'b1;
                                wr_data = proc_reg;
                            end
                        end
                        WL_OP_RELEASE:
                        begin
                            if (rd_data_reg == proc_reg)
                                take = 1'b1;
                        end
                        default:
                            take = 1'b0;
                    endcase
                end
                wr_en = take;
            end
            WL_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = rd_addr;
                idx_next = idx_reg + (WW + 1)'(1);
            end
            default:
                idx_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= WL_INIT;
            idx_reg      <= '0;
            init_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            wake_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= rd_en;
            done_reg    <= ((state_reg == WL_WALK) && last_cmp) ||
                           ((state_reg == WL_CLEAR) && (idx_reg[WW-1:0] == LAST_IDX));
            if (state_reg == WL_INIT)
                init_reg <= init_reg + AW'(1);
            if ((state_reg == WL_IDLE) && cmd.walk)
            begin
                hit_reg      <= 1'b0;
                wake_vld_reg <= 1'b0;
            end
            else if (cmp_vld_reg)
            begin
                if (take)
                    hit_reg <= 1'b1;
                else if ((op_reg == WL_OP_RELEASE) && (rd_data_reg != '0) && !wake_vld_reg)
                    wake_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_addr[WW-1:0] - base_reg[WW-1:0];
        if ((state_reg == WL_IDLE) && (cmd.walk || cmd.clear))
        begin
            base_reg <= AW'(int'(slot) * WAIT_SLOTS);
            op_reg   <= cmd.op;
            proc_reg <= proc;
            wake_reg <= '0;
        end
        else if (cmp_vld_reg && !take && (op_reg == WL_OP_RELEASE) &&
                 (rd_data_reg != '0) && !wake_vld_reg)
            wake_reg <= rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign sts.ready      = (state_reg == WL_IDLE);
    assign sts.done       = done_reg;
    assign sts.hit        = hit_reg;
    assign sts.wake_valid = wake_vld_reg;
    assign wake_proc      = wake_reg;

endmodule

// ===== rtl/binary_semaphore_table_unit.sv =====
// ----------------------------------------------------------------------------
// binary_semaphore_table_unit
// Table of named binary semaphores with per-semaphore wait lists.
//
//   channel  | handshake           | fields
//   ---------+---------------------+-------------------------------------------
//   request  | start, busy         | action, sem_id, proc_id
//   result   | done (1-cycle)      | status, block_caller, wake_valid, wake_proc
//
// A transaction with sem_id 0 answers the next cycle. Otherwise an id scan
// runs over the slot memory; terminate adds a wait-list row clear, and a
// queued down or an up on a held semaphore adds a wait-list walk. After
// reset busy stays high through the clearing passes of the slot and wait
// memories. Results cannot be stalled.
// ----------------------------------------------------------------------------
module binary_semaphore_table_unit #(
    parameter int NUM_SEMAPHORES = bst_pkg::NUM_SEMAPHORES_DEF,
    parameter int WAIT_SLOTS     = bst_pkg::WAIT_SLOTS_DEF,
    localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [bst_pkg::ACT_W-1:0]  action,
    input  logic [bst_pkg::ID_W-1:0]   sem_id,
    input  logic [bst_pkg::PROC_W-1:0] proc_id,
    output logic                       done,
    output logic [bst_pkg::STS_W-1:0]  status,
    output logic                       block_caller,
    output logic                       wake_valid,
    output logic [bst_pkg::PROC_W-1:0] wake_proc
);
    import bst_pkg::*;

    top_state_t        state_reg, state_next;
    action_t           act_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PROC_W-1:0] proc_reg;
    logic              done_reg;
    status_t           status_reg;
    logic              block_reg, wake_vld_reg;
    logic [PROC_W-1:0] wake_proc_reg;

    logic              accept, need_list;
    logic              emit;
    status_t           res_status;
    logic              res_block, res_wake_vld;
    logic [PROC_W-1:0] res_wake_proc;

    slot_cmd_t         slot_cmd;
    slot_sts_t         slot_sts;
    logic [SW-1:0]     wr_slot, match_slot, free_slot;
    wl_cmd_t           wl_cmd;
    wl_sts_t           wl_sts;
    logic [PROC_W-1:0] wl_wake;

    bst_slot_table #(
        .NUM_SEMAPHORES(NUM_SEMAPHORES)
    ) u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (slot_cmd),
        .key       (id_reg),
        .wr_slot   (wr_slot),
        .sts       (slot_sts),
        .match_slot(match_slot),
        .free_slot (free_slot)
    );

    bst_wait_list #(
        .NUM_SEMAPHORES(NUM_SEMAPHORES),
        .WAIT_SLOTS    (WAIT_SLOTS)
    ) u_waits (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (wl_cmd),
        .slot     (match_slot),
        .proc     (proc_reg),
        .sts      (wl_sts),
        .wake_proc(wl_wake)
    );

    assign busy   = (state_reg != TOP_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        need_list = 1'b0;
        if (slot_sts.found)
        begin
            unique case (act_reg)
                ACT_TERMINATE: need_list = 1'b1;
                ACT_DOWN:      need_list = !slot_sts.hit_flag;
                ACT_UP:        need_list = !slot_sts.hit_flag;
                default:       need_list = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TOP_INIT:
            begin
                if (slot_sts.ready && wl_sts.ready)
                    state_next = TOP_IDLE;
            end
            TOP_IDLE:
            begin
                if (accept && (sem_id != '0))
                    state_next = TOP_SCAN;
            end
            TOP_SCAN:
            begin
                if (slot_sts.done)
                    state_next = need_list ? TOP_LIST : TOP_IDLE;
            end
            TOP_LIST:
            begin
                if (wl_sts.done)
                    state_next = TOP_IDLE;
            end
            default:
                state_next = TOP_INIT;
        endcase
    end

    always_comb
    begin
        slot_cmd      = '0;
        wl_cmd        = '0;
        wr_slot       = match_slot;
        emit          = 1'b0;
        res_status    = ST_OK;
        res_block     = 1'b0;
        res_wake_vld  = 1'b0;
        res_wake_proc = '0;
        unique case (state_reg)
            TOP_INIT:
                emit = 1'b0;
            TOP_IDLE:
            begin
                if (accept)
                begin
                    if (sem_id == '0)
                    begin
                        emit       = 1'b1;
                        res_status = (action_t'(action) == ACT_CREATE) ? ST_EXISTS
                                                                       : ST_NOT_FOUND;
                    end
                    else
                        slot_cmd.scan = 1'b1;
                end
            end
            TOP_SCAN:
            begin
                if (slot_sts.done)
                begin
                    if (act_reg == ACT_CREATE)
                    begin
                        emit = 1'b1;
                        if (slot_sts.found)
                            res_status = ST_EXISTS;
                        else if (!slot_sts.free_found)
                            res_status = ST_NO_SPACE;
                        else
                        begin
                            wr_slot        = free_slot;
                            slot_cmd.write = 1'b1;
                            slot_cmd.flag  = 1'b1;
                        end
                    end
                    else if (!slot_sts.found)
                    begin
                        emit       = 1'b1;
                        res_status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        unique case (act_reg)
                            ACT_TERMINATE:
                            begin
                                slot_cmd.write = 1'b1;
                                slot_cmd.clear = 1'b1;
                                wl_cmd.clear   = 1'b1;
                            end
                            ACT_DOWN:
                            begin
                                if (slot_sts.hit_flag)
                                begin
                                    emit           = 1'b1;
                                    slot_cmd.write = 1'b1;
                                end
                                else
                                begin
                                    wl_cmd.walk = 1'b1;
                                    wl_cmd.op   = WL_OP_INSERT;
                                end
                            end
                            ACT_UP:
                            begin
                                if (slot_sts.hit_flag)
                                begin
                                    emit       = 1'b1;
                                    res_status = ST_NOT_HELD;
                                end
                                else
                                begin
                                    slot_cmd.write = 1'b1;
                                    slot_cmd.flag  = 1'b1;
                                    wl_cmd.walk    = 1'b1;
                                    wl_cmd.op      = WL_OP_RELEASE;
                                end
                            end
                            default:
                                emit = 1'b1;
                        endcase
                    end
                end
            end
            TOP_LIST:
            begin
                if (wl_sts.done)
                begin
                    emit = 1'b1;
                    unique case (act_reg)
                        ACT_DOWN:
                        begin
                            res_status = wl_sts.hit ? ST_OK : ST_WAIT_FULL;
                            res_block  = wl_sts.hit;
                        end
                        ACT_UP:
                        begin
                            res_wake_vld  = wl_sts.wake_valid;
                            res_wake_proc = wl_wake;
                        end
                        default:
                            res_status = ST_OK;
                    endcase
                end
            end
            default:
                emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TOP_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action_t'(action);
            id_reg   <= sem_id;
            proc_reg <= proc_id;
        end
        if (emit)
        begin
            status_reg    <= res_status;
            block_reg     <= res_block;
            wake_vld_reg  <= res_wake_vld;
            wake_proc_reg <= res_wake_proc;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign block_caller = block_reg;
    assign wake_valid   = wake_vld_reg;
    assign wake_proc    = wake_proc_reg;

endmodule

// ===== rtl/bst_checker.sv =====
// ----------------------------------------------------------------------------
// bst_port_checker
// Port-level checks for binary_semaphore_table_unit, attached by bind.
// ----------------------------------------------------------------------------
module bst_port_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [bst_pkg::STS_W-1:0]  status,
    input logic                       block_caller,
    input logic                       wake_valid,
    input logic [bst_pkg::PROC_W-1:0] wake_proc
);
    import bst_pkg::*;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither busy nor answered");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (!block_caller && !wake_valid))
        else $error("error result with block or wake set");

    a_wake_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && wake_valid) |-> ((wake_proc != '0) && (status == ST_OK)))
        else $error("wake names empty process");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

endmodule

bind binary_semaphore_table_unit bst_port_checker u_bst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .block_caller(block_caller),
    .wake_valid  (wake_valid),
    .wake_proc   (wake_proc)
);
